### rtl/ppm_pkg.sv
package ppm_pkg;

  localparam int CHANNELS_DEF = 9;
  localparam int TIME_W = 16;
  localparam int WORD_IDX_W = 4;
  localparam logic [TIME_W-1:0] SYNC_THRESHOLD_RST = 16'd8000;
  localparam logic [TIME_W-1:0] TIME_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_GAP   = 2'd0,
    MODE_PULSE = 2'd1,
    MODE_WAIT  = 2'd2
  } mode_t;

  typedef enum logic {
    REQ_EDGE = 1'b0,
    REQ_READ = 1'b1
  } req_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_WORD   = 1'b1
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic edge_go;
    logic read_go;
    logic word_load;
  } ppm_cmd_t;

  typedef struct packed {
    logic word_last;
  } ppm_status_t;

  // Time since then; a non-increasing stamp takes the wrap form now + max - then.
  function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] now,
                                                input logic [TIME_W-1:0] then);
    logic [TIME_W-1:0] res;
    if (now > then) begin
      res = now - then;
    end else begin
      res = now + (TIME_MAX - then);
    end
    return res;
  endfunction

endpackage

### rtl/ppm_ctrl.sv
module ppm_ctrl
  import ppm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        req_type,
  input  logic        out_ready,
  input  ppm_status_t status,
  output logic        in_ready,
  output logic        out_valid,
  output ppm_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic        out_valid_next;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        in_ready = out_free && !rst;
        if (in_valid && out_free && !rst) begin
          if (req_type == REQ_READ) begin
            cmd.read_go = 1'b1;
            state_next  = ST_READ;
          end else begin
            cmd.edge_go    = 1'b1;
            out_valid_next = 1'b1;
          end
        end
      end
      ST_READ: begin
        // stream one stored word per free output slot
        if (out_free) begin
          cmd.word_load  = 1'b1;
          out_valid_next = 1'b1;
          if (status.word_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/ppm_dp.sv
module ppm_dp
  import ppm_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [TIME_W-1:0]     cfg_wr_data,
  input  logic [TIME_W-1:0]     now_us,
  input  ppm_cmd_t              cmd,
  output ppm_status_t           status,
  output logic                  result_kind,
  output logic [WORD_IDX_W-1:0] word_index,
  output logic [TIME_W-1:0]     word_value,
  output logic                  last_word,
  output logic                  host_irq,
  output logic                  frame_done
);

  localparam int IDX_W = $clog2(CHANNELS + 1);
  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW    = $clog2(CHANNELS + 2);

  logic [TIME_W-1:0] sync_threshold;
  mode_t             mode, mode_next;
  logic [TIME_W-1:0] last_edge_time;
  logic [IDX_W-1:0]  channel_index, channel_index_next;
  logic              write_bank;
  logic [TIME_W-1:0] channel_store [2][CHANNELS];
  logic [TIME_W-1:0] capture_stamp [2];
  logic [TIME_W-1:0] sync_store [2];
  logic              irq_level, irq_next;
  logic [CW-1:0]     word_cnt;

  logic [TIME_W-1:0] width;
  logic              is_sync;
  logic              do_store;
  logic              do_done;
  logic              read_bank;
  logic [TIME_W-1:0] latency;
  logic [TIME_W-1:0] word_data;

  assign width     = elapsed(now_us, last_edge_time);
  assign is_sync   = width > sync_threshold;
  assign read_bank = ~write_bank;
  assign latency   = elapsed(now_us, capture_stamp[read_bank]);

  assign status.word_last = (word_cnt == CW'(CHANNELS + 1));

  always_comb begin
    mode_next          = mode;
    channel_index_next = channel_index;
    irq_next           = irq_level;
    do_store           = 1'b0;
    do_done            = 1'b0;
    if (mode == MODE_GAP) begin
      mode_next = MODE_PULSE;
    end else if (is_sync) begin
      mode_next          = MODE_GAP;
      channel_index_next = '0;
      irq_next           = 1'b0;
    end else if (mode == MODE_PULSE) begin
      if (channel_index < IDX_W'(CHANNELS)) begin
        do_store           = 1'b1;
        channel_index_next = channel_index + 1'b1;
      end
      if (channel_index_next < IDX_W'(CHANNELS)) begin
        mode_next = MODE_GAP;
      end else begin
        mode_next = MODE_WAIT;
        irq_next  = 1'b1;
        do_done   = 1'b1;
      end
    end
  end

  always_comb begin
    if (word_cnt < CW'(CHANNELS)) begin
      word_data = channel_store[read_bank][word_cnt[AW-1:0]];
    end else if (word_cnt == CW'(CHANNELS)) begin
      word_data = capture_stamp[read_bank];
    end else begin
      word_data = sync_store[read_bank];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_threshold <= SYNC_THRESHOLD_RST;
      mode           <= MODE_WAIT;
      last_edge_time <= '0;
      channel_index  <= '0;
      write_bank     <= 1'b0;
      irq_level      <= 1'b0;
      word_cnt       <= '0;
      for (int b = 0; b < 2; b++) begin
        capture_stamp[b] <= '0;
        sync_store[b]    <= '0;
        for (int c = 0; c < CHANNELS; c++) begin
          channel_store[b][c] <= '0;
        end
      end
    end else begin
      if (cfg_wr_en) begin
        sync_threshold <= cfg_wr_data;
      end
      if (cmd.edge_go) begin
        mode          <= mode_next;
        channel_index <= channel_index_next;
        irq_level     <= irq_next;
        if (mode != MODE_GAP) begin
          last_edge_time <= now_us;
        end
        if (mode != MODE_GAP && is_sync) begin
          sync_store[write_bank] <= width;
        end
        if (do_store) begin
          channel_store[write_bank][channel_index[AW-1:0]] <= width;
        end
        if (do_done) begin
          capture_stamp[write_bank] <= now_us;
          write_bank                <= ~write_bank;
        end
      end
      if (cmd.read_go) begin
        // latency replaces the stamp so the word stream reads it back
        capture_stamp[read_bank] <= latency;
        word_cnt                 <= '0;
      end else if (cmd.word_load) begin
        word_cnt <= word_cnt + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.edge_go) begin
      result_kind <= KIND_STATUS;
      word_index  <= '0;
      word_value  <= '0;
      last_word   <= 1'b1;
      host_irq    <= irq_next;
      frame_done  <= do_done;
    end else if (cmd.word_load) begin
      result_kind <= KIND_WORD;
      word_index  <= WORD_IDX_W'(word_cnt);
      word_value  <= word_data;
      last_word   <= status.word_last;
      host_irq    <= irq_level;
      frame_done  <= 1'b0;
    end
  end

endmodule

### rtl/ppm_frame_decoder_core.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_ready | req_type, now_us
// out     | output    | out_valid/out_ready | result_kind, word_index, word_value,
//         |           |                     | last_word, host_irq, frame_done
// cfg     | input     | cfg_wr_en           | cfg_wr_data (sync threshold)
//
// An edge item is taken and its status is registered, ready the next cycle;
// edges can follow back to back while the output drains.
// A read item first latches the latency, then streams one word per cycle from the
// bank register file while the output slot is free, CHANNELS+2 words in all.
// A stalled output holds its word; no new item is taken until the slot frees.
// rst is synchronous and clears all frame state and the bank store.
module ppm_frame_decoder_core
  import ppm_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [TIME_W-1:0]     cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [TIME_W-1:0]     now_us,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  result_kind,
  output logic [WORD_IDX_W-1:0] word_index,
  output logic [TIME_W-1:0]     word_value,
  output logic                  last_word,
  output logic                  host_irq,
  output logic                  frame_done
);

  ppm_cmd_t    cmd;
  ppm_status_t status;

  ppm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (req_type),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ppm_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .now_us      (now_us),
    .cmd         (cmd),
    .status      (status),
    .result_kind (result_kind),
    .word_index  (word_index),
    .word_value  (word_value),
    .last_word   (last_word),
    .host_irq    (host_irq),
    .frame_done  (frame_done)
  );

endmodule

### tb/ppm_frame_decoder_core_tb.sv
`timescale 1ns / 100ps
module ppm_frame_decoder_core_tb;
  import ppm_pkg::*;

  localparam int NCH = CHANNELS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 90;
  localparam int SETTLE_CYCLES = NCH + 8;
  localparam int MAX_SHOWN = 40;

  typedef struct {
    kind_t                 kind;
    logic [WORD_IDX_W-1:0] index;
    logic [TIME_W-1:0]     value;
    logic                  last;
    logic                  irq;
    logic                  done;
  } frame_word_t;

  // Decoder state plus the words it owes the host, in order.
  class ppm_decode_board;
    logic [TIME_W-1:0] threshold;
    mode_t             mode;
    logic [TIME_W-1:0] last_time;
    logic [3:0]        ch_idx;
    bit                wbank;
    logic [TIME_W-1:0] chan_store [2*NCH];
    logic [TIME_W-1:0] cap_stamp [2];
    logic [TIME_W-1:0] sync_width [2];
    logic              irq;
    frame_word_t       pending_words [$];
    int edges, reads, syncs, frames, checked, errors;

    function new();
      threshold = SYNC_THRESHOLD_RST;
      mode = MODE_WAIT;
      last_time = '0;
      ch_idx = '0;
      wbank = 1'b0;
      foreach (chan_store[k]) chan_store[k] = '0;
      cap_stamp[0] = '0;
      cap_stamp[1] = '0;
      sync_width[0] = '0;
      sync_width[1] = '0;
      irq = 1'b0;
    endfunction

    // Microseconds since an earlier stamp; a stamp that is not newer wraps as now + max - since.
    function logic [TIME_W-1:0] span16(logic [TIME_W-1:0] now, logic [TIME_W-1:0] since);
      if (now > since) return now - since;
      return now + (16'hFFFF - since);
    endfunction

    function void queue_word(kind_t kind, int index, logic [TIME_W-1:0] value, logic last,
                             logic done);
      frame_word_t w;
      w.kind = kind;
      w.index = index[WORD_IDX_W-1:0];
      w.value = value;
      w.last = last;
      w.irq = irq;
      w.done = done;
      pending_words.push_back(w);
    endfunction

    function void decode_item(req_t req, logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] width;
      logic [TIME_W-1:0] lat;
      bit                rbank;
      logic              done;
      if (req == REQ_EDGE) begin
        edges++;
        done = 1'b0;
        if (mode == MODE_GAP) begin
          mode = MODE_PULSE;
        end else begin
          width = span16(now, last_time);
          last_time = now;
          if (width > threshold) begin
            mode = MODE_GAP;
            ch_idx = '0;
            sync_width[wbank] = width;
            irq = 1'b0;
            syncs++;
          end else if (mode == MODE_PULSE) begin
            if (ch_idx < NCH) begin
              chan_store[int'(wbank) * NCH + int'(ch_idx)] = width;
              ch_idx = ch_idx + 4'd1;
            end
            if (ch_idx < NCH && ch_idx != 0) begin
              mode = MODE_GAP;
            end else begin
              // last channel: stamp, swap banks, raise the interrupt
              mode = MODE_WAIT;
              cap_stamp[wbank] = now;
              wbank = ~wbank;
              irq = 1'b1;
              done = 1'b1;
              frames++;
            end
          end
        end
        queue_word(KIND_STATUS, 0, '0, 1'b1, done);
      end else begin
        reads++;
        rbank = ~wbank;
        lat = span16(now, cap_stamp[rbank]);
        cap_stamp[rbank] = lat;
        for (int k = 0; k < NCH; k++)
          queue_word(KIND_WORD, k, chan_store[int'(rbank) * NCH + k], 1'b0, 1'b0);
        queue_word(KIND_WORD, NCH, lat, 1'b0, 1'b0);
        queue_word(KIND_WORD, NCH + 1, sync_width[rbank], 1'b1, 1'b0);
      end
    endfunction

    task log_mismatch(string msg);
      errors++;
      if (errors <= MAX_SHOWN) $display("MISMATCH: %s", msg);
    endtask

    task compare_word(kind_t kind, logic [WORD_IDX_W-1:0] index, logic [TIME_W-1:0] value,
                      logic last, logic irq_out, logic done);
      frame_word_t e;
      if (pending_words.size() == 0) begin
        log_mismatch($sformatf("result with nothing pending: kind %0d index %0d value %0d",
                               kind, index, value));
        return;
      end
      e = pending_words.pop_front();
      if (kind !== e.kind)
        log_mismatch($sformatf("result %0d result_kind %0d, want %0d", checked, kind, e.kind));
      if (index !== e.index)
        log_mismatch($sformatf("result %0d word_index %0d, want %0d", checked, index, e.index));
      if (value !== e.value)
        log_mismatch($sformatf("result %0d word_value %0d, want %0d", checked, value, e.value));
      if (last !== e.last)
        log_mismatch($sformatf("result %0d last_word %0b, want %0b", checked, last, e.last));
      if (irq_out !== e.irq)
        log_mismatch($sformatf("result %0d host_irq %0b, want %0b", checked, irq_out, e.irq));
      if (done !== e.done)
        log_mismatch($sformatf("result %0d frame_done %0b, want %0b", checked, done, e.done));
      checked++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [TIME_W-1:0]     cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  req_type = 1'b0;
  logic [TIME_W-1:0]     now_us = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  result_kind;
  logic [WORD_IDX_W-1:0] word_index;
  logic [TIME_W-1:0]     word_value;
  logic                  last_word;
  logic                  host_irq;
  logic                  frame_done;

  ppm_decode_board board;
  ppm_decode_board lookahead;   // tracks state as items are issued, to aim timestamps
  logic [TIME_W-1:0] threshold_now = SYNC_THRESHOLD_RST;
  logic [TIME_W-1:0] last_threshold;
  logic [TIME_W-1:0] dir_widths [7] = '{16'd1, 16'd1500, 16'd2100, 16'd900, 16'd7999,
                                        16'd1234, 16'd8000};
  int unsigned cycle_count = 0;
  int unsigned ready_span;
  int          items_sent = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  ppm_frame_decoder_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .now_us      (now_us),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .word_index  (word_index),
    .word_value  (word_value),
    .last_word   (last_word),
    .host_irq    (host_irq),
    .frame_done  (frame_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               board.pending_words.size());
      $display("ppm_frame_decoder_core verification failed");
      $finish;
    end
  end

  // Note the accepted item before checking results of the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.decode_item(req_t'(req_type), now_us);
      if (out_valid && out_ready)
        board.compare_word(kind_t'(result_kind), word_index, word_value, last_word, host_irq,
                           frame_done);
    end
  end

  // Output side: random stalls, one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        ready_span = $urandom_range(1, 12);
        repeat (ready_span - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        ready_span = quiet ? 1 : $urandom_range(1, 12);
        repeat (ready_span - 1) @(posedge clk);
      end
    end
  end

  task automatic send_item(input req_t r, input logic [TIME_W-1:0] n);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r;
    now_us <= n;
    lookahead.decode_item(r, n);
    lookahead.pending_words.delete();
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Hold input until every owed word has come, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      #1;
    end while (board.pending_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [TIME_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.threshold = v;
    lookahead.threshold = v;
    threshold_now = v;
  endtask

  // Timestamp that makes the next measured edge come out at the given width.
  function automatic logic [TIME_W-1:0] stamp_for(input logic [TIME_W-1:0] width);
    logic [TIME_W:0] sum;
    sum = {1'b0, lookahead.last_time} + width;
    if (!sum[TIME_W]) return sum[TIME_W-1:0];
    return sum[TIME_W-1:0] + 16'd1;
  endfunction

  function automatic logic [TIME_W-1:0] pick_channel_width();
    int unsigned w;
    w = $urandom_range(900, 2100);
    case ($urandom_range(0, 9))
      0: w = 32'(threshold_now);
      1, 2: w = $urandom_range(1, threshold_now);
      default: ;
    endcase
    if (w > threshold_now) w = $urandom_range(1, threshold_now);
    return w[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] pick_sync_width();
    int unsigned w;
    if ($urandom_range(0, 4) == 0) w = int'(threshold_now) + 1;
    else w = $urandom_range(int'(threshold_now) + 1, 65535);
    return w[TIME_W-1:0];
  endfunction

  task automatic send_frame(input int n_ch);
    if (lookahead.mode == MODE_GAP) send_item(REQ_EDGE, TIME_W'($urandom_range(0, 65535)));
    send_item(REQ_EDGE, stamp_for(pick_sync_width()));
    for (int k = 0; k < n_ch; k++) begin
      send_item(REQ_EDGE, TIME_W'($urandom_range(0, 65535)));
      send_item(REQ_EDGE, stamp_for(pick_channel_width()));
    end
  endtask

  task automatic run_traffic(input int n_items, input bit frames_ok);
    int stop;
    int pick;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (frames_ok && pick < 55) begin
        send_frame(NCH);
        if ($urandom_range(0, 1)) send_item(REQ_READ, TIME_W'($urandom_range(0, 65535)));
      end else if (frames_ok && pick < 65) begin
        send_frame($urandom_range(0, NCH - 1));
      end else if (pick < 80) begin
        send_item(REQ_READ, TIME_W'($urandom_range(0, 65535)));
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 4)) send_item(REQ_EDGE, TIME_W'($urandom_range(0, 65535)));
      end else if (!quiet) begin
        drain();
      end
    end
  endtask

  initial begin
    board = new();
    lookahead = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // read before any frame, then a non-sync edge while waiting, an equal stamp as sync,
    // a sync from the pulse phase, a zero-width channel via the wrap formula
    send_item(REQ_READ, 16'd0);
    send_item(REQ_EDGE, 16'd100);
    send_item(REQ_EDGE, 16'd100);
    send_item(REQ_EDGE, 16'd5000);
    send_item(REQ_EDGE, 16'hFFFF);
    send_item(REQ_EDGE, 16'd3);
    send_item(REQ_EDGE, 16'd0);
    send_item(REQ_EDGE, 16'd4242);
    send_item(REQ_EDGE, stamp_for(threshold_now));
    for (int k = 0; k < 7; k++) begin
      send_item(REQ_EDGE, 16'hA5A5 ^ k[TIME_W-1:0]);
      send_item(REQ_EDGE, stamp_for(dir_widths[k]));
    end
    // second read sees the latency written back over the capture stamp
    send_item(REQ_READ, 16'd30000);
    send_item(REQ_READ, 16'd12);
    drain();

    write_threshold(16'd0);
    run_traffic(20, 1'b0);
    drain();
    write_threshold(16'hFFFF);
    run_traffic(20, 1'b0);
    drain();
    write_threshold(16'd2500);
    hold_req = 1'b1;
    run_traffic(150, 1'b1);
    drain();
    last_threshold = TIME_W'($urandom_range(3000, 30000));
    write_threshold(last_threshold);
    run_traffic(80, 1'b1);
    hold_req = 1'b1;
    run_traffic(20, 1'b1);
    quiet = 1'b1;
    run_traffic(50, 1'b1);
    drain();

    if (board.pending_words.size() != 0)
      board.log_mismatch($sformatf("%0d expected results never arrived",
                                   board.pending_words.size()));
    $display("run covered %0d pin edges, %0d syncs, %0d completed frames, %0d host reads",
             board.edges, board.syncs, board.frames, board.reads);
    $display("%0d result words checked over thresholds 8000, 0, 65535, 2500, %0d; %0d errors",
             board.checked, last_threshold, board.errors);
    if (board.errors == 0) begin
      $display("ppm_frame_decoder_core verification clean");
    end else begin
      $display("ppm_frame_decoder_core verification failed");
    end
    $finish;
  end

endmodule
